FILE: sv/hsr_pkg.sv
// Shared constants for the Heron square root pipeline.
package hsr_pkg;
	localparam int RADICAND_W = 17;
	localparam int ROOT_W     = 32;
endpackage

FILE: sv/hsr_if.sv
// Valid/ready channel interfaces for radicand input and root output.
interface hsr_radicand_if import hsr_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [RADICAND_W-1:0] radicand;
	modport source (output valid, output radicand, input ready);
	modport sink   (input valid, input radicand, output ready);
endinterface

interface hsr_root_if import hsr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ROOT_W-1:0] root_estimate;
	modport source (output valid, output root_estimate, input ready);
	modport sink   (input valid, input root_estimate, output ready);
endinterface

FILE: sv/heron_square_root_top.sv
// Top level of the Heron square root: entry stage, chain of division cells, output register.
//
//  channel       dir  payload              width  format
//  radicand_ch   in   radicand             17     unsigned integer
//  root_ch       out  root_estimate        32     unsigned Q16.16 (FRACTION_BITS)
//
// The pipeline registers are one entry stage, one cell per quotient bit per Heron step,
// and one output register.
// A new radicand is taken every cycle unless the chain holds; throughput is one transfer per cycle.
// The whole chain advances together; it holds only while the output register
// is full and root_ch.ready is low. Reset clears the valid bits alone.
module heron_square_root_top import hsr_pkg::*; #(
	parameter int STEP_COUNT    = 10,
	parameter int INPUT_BITS    = 17,
	parameter int FRACTION_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	hsr_radicand_if.sink  radicand_ch,
	hsr_root_if.source    root_ch
);
	// estimate width and numerator width of each long division
	localparam int XW    = INPUT_BITS + FRACTION_BITS + 1;
	localparam int NB    = INPUT_BITS + 2 * FRACTION_BITS;
	localparam int SHIFT = 2 * FRACTION_BITS;
	localparam int NCELL = STEP_COUNT * NB;
	localparam int XWX   = (XW > ROOT_W) ? XW : ROOT_W + 1;

	logic                  en;
	logic [INPUT_BITS-1:0] r_in;
	logic [XW-1:0]         x0;
	logic                  v_s1;
	logic [INPUT_BITS-1:0] r_s1;
	logic [XW-1:0]         x_s1;

	logic                  v_c   [NCELL+1];
	logic [INPUT_BITS-1:0] r_c   [NCELL+1];
	logic [XW-1:0]         x_c   [NCELL+1];
	logic [XW-1:0]         rem_c [NCELL+1];
	logic [NB-1:0]         q_c   [NCELL+1];

	logic [XWX-1:0]        x_ext;
	logic [ROOT_W-1:0]     root_n;
	logic                  out_v_q;
	logic [ROOT_W-1:0]     root_q;

	// Global advance: stall only when the result is held and not taken.
	assign en                = !out_v_q || root_ch.ready;
	assign radicand_ch.ready = en;

	// Start estimate R/2 in fixed point, raised to one LSB if it comes out zero.
	always_comb begin
		r_in = INPUT_BITS'(radicand_ch.radicand);
		x0   = (XW'(r_in) << FRACTION_BITS) >> 1;
		if (x0 == '0) begin
			x0 = XW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= radicand_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1 <= r_in;
			x_s1 <= x0;
		end
	end

	assign v_c[0]   = v_s1;
	assign r_c[0]   = r_s1;
	assign x_c[0]   = x_s1;
	assign rem_c[0] = '0;
	assign q_c[0]   = '0;

	// One cell per quotient bit; the last cell of each step forms the new estimate.
	for (genvar k = 0; k < NCELL; k++) begin : g_cell
		hsr_cell #(
			.IB    (INPUT_BITS),
			.XW    (XW),
			.NB    (NB),
			.SHIFT (SHIFT),
			.POS   (NB - 1 - (k % NB)),
			.LAST  ((k % NB) == NB - 1)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.v_in    (v_c[k]),
			.r_in    (r_c[k]),
			.x_in    (x_c[k]),
			.rem_in  (rem_c[k]),
			.q_in    (q_c[k]),
			.v_out   (v_c[k+1]),
			.r_out   (r_c[k+1]),
			.x_out   (x_c[k+1]),
			.rem_out (rem_c[k+1]),
			.q_out   (q_c[k+1])
		);
	end

	// Zero radicand gives zero; otherwise saturate to the output width.
	always_comb begin
		x_ext = XWX'(x_c[NCELL]);
		if (r_c[NCELL] == '0) begin
			root_n = '0;
		end else if ((x_ext >> ROOT_W) != '0) begin
			root_n = '1;
		end else begin
			root_n = ROOT_W'(x_ext);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= v_c[NCELL];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			root_q <= root_n;
		end
	end

	assign root_ch.valid         = out_v_q;
	assign root_ch.root_estimate = root_q;
endmodule

FILE: sv/hsr_cell.sv
// One restoring-division cell: one quotient bit; the step's last cell also updates the estimate.
module hsr_cell import hsr_pkg::*; #(
	parameter int IB    = 17,
	parameter int XW    = 34,
	parameter int NB    = 49,
	parameter int SHIFT = 32,
	parameter int POS   = 0,
	parameter bit LAST  = 1'b0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          v_in,
	input  logic [IB-1:0] r_in,
	input  logic [XW-1:0] x_in,
	input  logic [XW-1:0] rem_in,
	input  logic [NB-1:0] q_in,
	output logic          v_out,
	output logic [IB-1:0] r_out,
	output logic [XW-1:0] x_out,
	output logic [XW-1:0] rem_out,
	output logic [NB-1:0] q_out
);
	localparam int RIDX = (POS >= SHIFT) ? POS - SHIFT : 0;

	logic          num_bit;
	logic [XW:0]   trial;
	logic          ge;
	logic [XW:0]   diff;
	logic [XW-1:0] rem_n;
	logic [NB-1:0] q_n;
	logic [NB:0]   nx_w;
	logic [XW-1:0] nx;
	logic          v_s1;
	logic [IB-1:0] r_s1;
	logic [XW-1:0] x_s1;
	logic [XW-1:0] rem_s1;
	logic [NB-1:0] q_s1;

	always_comb begin
		num_bit = (POS >= SHIFT) ? r_in[RIDX] : 1'b0;
		trial   = {rem_in, num_bit};
		ge      = trial >= {1'b0, x_in};
		diff    = trial - {1'b0, x_in};
		rem_n   = ge ? diff[XW-1:0] : trial[XW-1:0];
		q_n     = {q_in[NB-2:0], ge};
		// floor((x + q) / 2) without overflow
		nx_w    = (NB+1)'(x_in >> 1) + (NB+1)'(q_n >> 1)
		        + (NB+1)'(x_in[0] & q_n[0]);
		nx      = XW'(nx_w);
		if (nx == '0) begin
			nx = XW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1 <= r_in;
			if (LAST) begin
				x_s1   <= nx;
				rem_s1 <= '0;
				q_s1   <= '0;
			end else begin
				x_s1   <= x_in;
				rem_s1 <= rem_n;
				q_s1   <= q_n;
			end
		end
	end

	assign v_out   = v_s1;
	assign r_out   = r_s1;
	assign x_out   = x_s1;
	assign rem_out = rem_s1;
	assign q_out   = q_s1;
endmodule

FILE: sv/hsr_checker.sv
// Port-level checks for the Heron square root top level, bound to it.
module hsr_checker import hsr_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [ROOT_W-1:0] root_estimate
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(root_estimate))
		else $error("result changed while stalled");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

	a_ready_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |-> in_ready)
		else $error("input blocked while output drains");
endmodule

bind heron_square_root_top hsr_checker u_hsr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (radicand_ch.ready),
	.out_valid     (root_ch.valid),
	.out_ready     (root_ch.ready),
	.root_estimate (root_ch.root_estimate)
);
